// ===== hw/rtl/gmw_pkg.sv =====
package gmw_pkg;

   localparam int MaxWidth  = 4096;
   localparam int MaxHeight = 4096;
   localparam int MaxSe     = 19;
   localparam int MaxRadius = (MaxSe - 1) / 2;
   localparam int ColW      = $clog2(MaxWidth);
   localparam int SlotW     = $clog2(MaxSe);
   localparam int ItemW     = 1 + 8 + 5 + MaxSe;
   localparam int QDepth    = 4;
   localparam int QPtrW     = $clog2(QDepth);

   localparam logic [1:0] CSR_MODE   = 2'd0;
   localparam logic [1:0] CSR_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_HEIGHT = 2'd2;
   localparam logic [1:0] CSR_RADIUS = 2'd3;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_SE    = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [7:0]  pixel;
      logic [4:0]  se_row;
      logic [18:0] se_bits;
   } req_type;

   typedef struct packed {
      logic [7:0]  value;
      logic [11:0] x_first;
      logic [11:0] x_last;
      logic [11:0] y_first;
      logic [11:0] y_last;
      logic        frame_last;
   } rsp_type;

   typedef struct packed {
      logic [ColW:0] w;
      logic [ColW:0] h;
      logic [3:0]    r;
      logic          mode;
   } cfg_type;

endpackage

// ===== hw/rtl/gmw_queue.sv =====
module gmw_queue import gmw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  req_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output req_type pop_data
);
   req_type           mem_ff [QDepth];
   logic [QPtrW-1:0]  wp_ff, wp_in, rp_ff, rp_in;
   logic [QPtrW:0]    cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign full     = (cnt_ff == (QPtrW+1)'(QDepth));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rp_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wp_in  = do_push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = do_pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (QPtrW+1)'(do_push) - (QPtrW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wp_ff] <= push_data;
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end
endmodule

// ===== hw/rtl/gmw_engine.sv =====
module gmw_engine import gmw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    in_valid,
   input  req_type in_item,
   output logic    in_ready,
   output logic    out_valid,
   output rsp_type out_item,
   input  logic    out_ready
);
   // line memory, one bank per row slot, each bank read at one address a cycle unless the pipeline stalls
   logic [MaxSe-1:0] mask_ff [MaxSe];
   logic [ColW:0] col_ff, col_in, row_ff, row_in;
   logic [SlotW-1:0] slot_ff, slot_in;
   // window shift registers, column MaxSe-1 is newest
   logic [7:0]  win_ff [MaxSe][MaxSe];
   logic [7:0]  col_rd [MaxSe];

   // stage 1 register
   logic        s1_v_ff, s1_emit_ff, s1_last_ff;
   logic [ColW:0] s1_col_ff, s1_row_ff;
   logic [7:0]  s1_pix_ff;
   logic [SlotW-1:0] s1_slot_ff;
   logic        s2_v_ff;
   rsp_type     s2_ff;
   logic [7:0]  rowacc_ff [MaxSe];
   logic        s3_v_ff;
   rsp_type     s3_ff;
   rsp_type     s3_in;

   logic        stall, take, pix, emit, last;
   logic [ColW:0] two_r;
   logic [4:0]  side;

   assign side  = {cfg.r, 1'b1};
   assign two_r = (ColW+1)'({cfg.r, 1'b0});
   assign stall = out_valid && !out_ready && s3_v_ff;
   assign in_ready = !stall;
   assign take  = in_valid && in_ready;
   assign pix   = take && (in_item.operation == OP_PIXEL);
   assign emit  = (col_ff >= two_r) && (row_ff >= two_r)
                  && (col_ff < cfg.w) && (row_ff < cfg.h);
   assign last  = (col_ff == cfg.w - 1'b1) && (row_ff == cfg.h - 1'b1);

   always_comb begin
      col_in = col_ff; row_in = row_ff; slot_in = slot_ff;
      if (pix) begin
         col_in = col_ff + 1'b1;
         if (col_in >= cfg.w) begin
            col_in = '0;
            row_in = row_ff + 1'b1;
            slot_in = (slot_ff == SlotW'(MaxSe-1)) ? '0 : slot_ff + 1'b1;
         end
         if (row_in >= cfg.h) begin
            row_in = '0;
            slot_in = '0;
         end
      end
   end

   // write the pixel into its bank and read the column of the window ending at it;
   // hold the read data while the pipeline stalls
   for (genvar b = 0; b < MaxSe; b++) begin : g_bank
      logic [7:0] bank_mem [MaxWidth];
      logic [7:0] rd_ff;
      always_ff @(posedge clock) begin
         if (pix && slot_ff == SlotW'(b)) begin
            bank_mem[col_ff[ColW-1:0]] <= in_item.pixel;
         end
         if (!stall) begin
            rd_ff <= bank_mem[col_ff[ColW-1:0]];
         end
      end
      assign col_rd[b] = rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MaxSe; i++) mask_ff[i] <= '0;
         col_ff <= '0; row_ff <= '0; slot_ff <= '0;
         s1_v_ff <= 1'b0; s2_v_ff <= 1'b0; s3_v_ff <= 1'b0;
      end else begin
         if (take && in_item.operation == OP_SE && in_item.se_row < 5'(MaxSe))
            mask_ff[in_item.se_row] <= in_item.se_bits;
         if (!stall) begin
            col_ff <= col_in; row_ff <= row_in; slot_ff <= slot_in;
            s1_v_ff <= pix;
            s2_v_ff <= s1_v_ff && s1_emit_ff;
            s3_v_ff <= s2_v_ff;
         end
      end
   end

   // stage 1 carries position; the memory read lands in col_rd
   always_ff @(posedge clock) begin
      if (!stall) begin
         s1_emit_ff <= emit; s1_last_ff <= last;
         s1_col_ff <= col_ff; s1_row_ff <= row_ff;
         s1_pix_ff <= in_item.pixel; s1_slot_ff <= slot_ff;
      end
   end

   // stage 2: shift window, newest column from memory with bypass
   logic [7:0] newc [MaxSe];
   logic [7:0] wn [MaxSe][MaxSe];
   logic [7:0] acc2 [MaxSe];
   logic [7:0] tr [32];
   int         sl_sum;
   logic [SlotW-1:0] sl;
   logic [ColW:0] cx, cy;
   always_comb begin
      for (int i = 0; i < MaxSe; i++)
         newc[i] = (i == int'(s1_slot_ff)) ? s1_pix_ff : col_rd[i];
      for (int yy = 0; yy < MaxSe; yy++) begin
         for (int xx = 0; xx < MaxSe - 1; xx++) wn[yy][xx] = win_ff[yy][xx+1];
         wn[yy][MaxSe-1] = newc[yy];
      end
      // row yi uses slot (row-2r+yi) mod MaxSe, column xi is at MaxSe-side+xi;
      // each row reduces through a five-level comparator tree
      for (int yi = 0; yi < MaxSe; yi++) begin
         sl_sum = int'(s1_slot_ff) + MaxSe - 2 * int'(cfg.r) + yi;
         if (sl_sum >= MaxSe) sl_sum = sl_sum - MaxSe;
         if (sl_sum >= MaxSe) sl_sum = sl_sum - MaxSe;
         sl = SlotW'(sl_sum);
         for (int xi = 0; xi < 32; xi++) tr[xi] = cfg.mode ? 8'd0 : 8'd255;
         for (int xi = 0; xi < MaxSe; xi++) begin
            if (yi < int'(side) && xi < int'(side) && mask_ff[yi][xi])
               tr[xi] = wn[sl][MaxSe-int'(side)+xi];
         end
         for (int s = 16; s > 0; s = s >> 1) begin
            for (int i = 0; i < s; i++) begin
               if (cfg.mode) tr[i] = (tr[2*i+1] > tr[2*i]) ? tr[2*i+1] : tr[2*i];
               else          tr[i] = (tr[2*i+1] < tr[2*i]) ? tr[2*i+1] : tr[2*i];
            end
         end
         acc2[yi] = tr[0];
      end
      cx = s1_col_ff - (ColW+1)'(cfg.r);
      cy = s1_row_ff - (ColW+1)'(cfg.r);
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         if (s1_v_ff) win_ff <= wn;
         rowacc_ff <= acc2;
         s2_ff.value <= '0;
         s2_ff.x_first <= (cx == (ColW+1)'(cfg.r)) ? '0 : cx[11:0];
         s2_ff.x_last  <= (cx == cfg.w - 1'b1 - (ColW+1)'(cfg.r)) ?
                          12'(cfg.w - 1'b1) : cx[11:0];
         s2_ff.y_first <= (cy == (ColW+1)'(cfg.r)) ? '0 : cy[11:0];
         s2_ff.y_last  <= (cy == cfg.h - 1'b1 - (ColW+1)'(cfg.r)) ?
                          12'(cfg.h - 1'b1) : cy[11:0];
         s2_ff.frame_last <= s1_last_ff;
      end
   end

   // stage 3: combine row results through a comparator tree
   logic [7:0] tf [32];
   always_comb begin
      for (int i = 0; i < 32; i++) tf[i] = cfg.mode ? 8'd0 : 8'd255;
      for (int i = 0; i < MaxSe; i++) tf[i] = rowacc_ff[i];
      for (int s = 16; s > 0; s = s >> 1) begin
         for (int i = 0; i < s; i++) begin
            if (cfg.mode) tf[i] = (tf[2*i+1] > tf[2*i]) ? tf[2*i+1] : tf[2*i];
            else          tf[i] = (tf[2*i+1] < tf[2*i]) ? tf[2*i+1] : tf[2*i];
         end
      end
      s3_in = s2_ff;
      s3_in.value = tf[0];
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         s3_ff <= s3_in;
      end
   end

   assign out_valid = s3_v_ff;
   assign out_item  = s3_ff;
endmodule

// ===== hw/rtl/gmw_out_queue.sv =====
module gmw_out_queue import gmw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  rsp_type in_item,
   output logic    in_ready,
   output logic    empty,
   output rsp_type out_item,
   input  logic    pop
);
   rsp_type        mem_ff [QDepth];
   logic [QPtrW-1:0] wp_ff, rp_ff;
   logic [QPtrW:0] cnt_ff;
   logic           wr, rd;

   assign in_ready = (cnt_ff < (QPtrW+1)'(QDepth));
   assign empty    = (cnt_ff == '0);
   assign out_item = mem_ff[rp_ff];
   assign wr = in_valid && in_ready;
   assign rd = pop && !empty;

   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= in_item;
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= wp_ff + 1'b1;
         if (rd) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (QPtrW+1)'(wr) - (QPtrW+1)'(rd);
      end
   end
endmodule

// ===== hw/rtl/grayscale_morphology_window.sv =====
// Grayscale erosion/dilation over a flat structuring element, raster input.
// Request channel: a queue input (push/full). Each request is either a pixel
// or one structuring-element row load. Response channel: a queue output
// (empty/pop) carrying one window result with the rectangle it fills.
// Configuration: csr_write with csr_index 0 mode, 1 width, 2 height,
// 3 radius; write only while the block is idle.
// Path: a pixel that completes a window passes the input queue, line read,
// row reduction, merge and output queue before its result reaches the
// response ports, where it can be popped.
// Throughput: one request per cycle while the output is drained, set by the
// line banks (one write and one read per bank each cycle) and comparator trees.
// Reset clears counters, mask rows and queues; line memory holds stale data
// that is always rewritten before use within a frame.
// If the receiver stops popping, the output queue fills, the engine holds,
// then the input queue fills and full rises.
module grayscale_morphology_window import gmw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  req_type     req_data,
   output logic        full,
   output logic        empty,
   input  logic        pop,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);
   logic        mode_ff;
   logic [12:0] width_ff, height_ff;
   logic [3:0]  radius_ff;
   cfg_type     cfg;
   logic        q_empty, q_pop, e_ready, e_valid, o_ready;
   req_type     q_data;
   rsp_type     e_item;

   // hold registers; saturate to effective values for the engine
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0; width_ff <= 13'd4096; height_ff <= 13'd4096;
         radius_ff <= 4'd9;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MODE:   mode_ff   <= csr_data[0];
            CSR_WIDTH:  width_ff  <= csr_data;
            CSR_HEIGHT: height_ff <= csr_data;
            CSR_RADIUS: radius_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.mode = mode_ff;
      cfg.w = (width_ff == '0) ? 13'd1 : (width_ff > 13'(MaxWidth)) ?
              13'(MaxWidth) : width_ff;
      cfg.h = (height_ff == '0) ? 13'd1 : (height_ff > 13'(MaxHeight)) ?
              13'(MaxHeight) : height_ff;
      cfg.r = (radius_ff > 4'(MaxRadius)) ? 4'(MaxRadius) : radius_ff;
   end

   gmw_queue u_inq (
      .clock(clock), .reset(reset), .push(push), .push_data(req_data),
      .full(full), .pop(q_pop), .empty(q_empty), .pop_data(q_data)
   );

   assign q_pop = e_ready && !q_empty;

   gmw_engine u_eng (
      .clock(clock), .reset(reset), .cfg(cfg),
      .in_valid(!q_empty), .in_item(q_data), .in_ready(e_ready),
      .out_valid(e_valid), .out_item(e_item), .out_ready(o_ready)
   );

   gmw_out_queue u_outq (
      .clock(clock), .reset(reset), .in_valid(e_valid), .in_item(e_item),
      .in_ready(o_ready), .empty(empty), .out_item(rsp_data), .pop(pop)
   );
endmodule

// ===== tb/sv/grayscale_morphology_window_checker.sv =====
`timescale 1ns / 100ps

module grayscale_morphology_window_checker import gmw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  req_type     req_data,
   input  logic        pop,
   input  logic        empty,
   input  rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data,
   output int          errors,
   output int          pending
);

   // Mirror of the block: settings, mask rows, recent rows, raster position.
   logic        m_mode;
   logic [12:0] m_width;
   logic [12:0] m_height;
   logic [3:0]  m_radius;
   bit [18:0]   mask_rows [0:MaxSe-1];
   bit [7:0]    recent_rows [0:MaxSe-1][0:MaxWidth-1];
   int unsigned col_pos;
   int unsigned row_pos;
   rsp_type     window_results [$];

   assign pending = window_results.size();

   function automatic int unsigned clamp_size(int unsigned v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   // Work out the window result for one accepted request, if any.
   task automatic predict_window(req_type q);
      int unsigned w, h, r, side, acc, cx, cy, slot, p;
      rsp_type     res;
      w = clamp_size(m_width, MaxWidth);
      h = clamp_size(m_height, MaxHeight);
      r = (m_radius > MaxRadius) ? MaxRadius : m_radius;
      side = 2 * r + 1;
      if (q.operation == OP_SE) begin
         if (q.se_row < MaxSe) mask_rows[q.se_row] = q.se_bits;
         return;
      end
      recent_rows[row_pos % MaxSe][col_pos] = q.pixel;
      if (!(col_pos >= w || row_pos >= h || col_pos < 2 * r || row_pos < 2 * r)) begin
         acc = m_mode ? 0 : 255;
         for (int yi = 0; yi < side; yi++) begin
            slot = (row_pos - 2 * r + yi) % MaxSe;
            for (int xi = 0; xi < side; xi++) begin
               if (mask_rows[yi][xi]) begin
                  p = recent_rows[slot][col_pos - 2 * r + xi];
                  if (m_mode) begin
                     if (p > acc) acc = p;
                  end else begin
                     if (p < acc) acc = p;
                  end
               end
            end
         end
         cx = col_pos - r;
         cy = row_pos - r;
         res.value      = acc[7:0];
         res.x_first    = (cx == r) ? 12'd0 : cx[11:0];
         res.x_last     = (cx == w - 1 - r) ? 12'(w - 1) : cx[11:0];
         res.y_first    = (cy == r) ? 12'd0 : cy[11:0];
         res.y_last     = (cy == h - 1 - r) ? 12'(h - 1) : cy[11:0];
         res.frame_last = (col_pos == w - 1) && (row_pos == h - 1);
         window_results.push_back(res);
      end
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) row_pos = 0;
      end
      if (row_pos >= h) row_pos = 0;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         m_mode   = 1'b0;
         m_width  = 13'd4096;
         m_height = 13'd4096;
         m_radius = 4'd9;
         foreach (mask_rows[i]) mask_rows[i] = '0;
         col_pos  = 0;
         row_pos  = 0;
         window_results.delete();
         errors   = 0;
      end else begin
         if (pop && !empty) begin
            if (window_results.size() == 0) begin
               $display("%0t: unexpected result %p", $time, rsp_data);
               errors++;
            end else begin
               want = window_results.pop_front();
               if (rsp_data.value !== want.value || rsp_data.x_first !== want.x_first ||
                   rsp_data.x_last !== want.x_last || rsp_data.y_first !== want.y_first ||
                   rsp_data.y_last !== want.y_last ||
                   rsp_data.frame_last !== want.frame_last) begin
                  $display("%0t: mismatch expected %p actual %p", $time, want, rsp_data);
                  errors++;
               end
            end
         end
         if (push && !full) predict_window(req_data);
         if (csr_write) begin
            case (csr_index)
               CSR_MODE:   m_mode   = csr_data[0];
               CSR_WIDTH:  m_width  = csr_data;
               CSR_HEIGHT: m_height = csr_data;
               CSR_RADIUS: m_radius = csr_data[3:0];
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== tb/sv/grayscale_morphology_window_tb.sv =====
`timescale 1ns / 100ps

module grayscale_morphology_window_tb import gmw_pkg::*;;

   localparam int CycleLimit = 600000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   req_type     req_data = '0;
   logic        full;
   logic        empty;
   logic        pop = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = CSR_MODE;
   logic [12:0] csr_data = '0;
   int          errors;
   int          pending;
   int unsigned requests_sent = 0;
   int unsigned cycles = 0;
   bit          quiet = 1'b0;

   always #4 clock = ~clock;

   grayscale_morphology_window dut (
      .clock, .reset, .push, .req_data, .full, .empty, .pop, .rsp_data,
      .csr_write, .csr_index, .csr_data
   );

   grayscale_morphology_window_checker checker_i (
      .clock, .reset, .push, .full, .req_data, .pop, .empty, .rsp_data,
      .csr_write, .csr_index, .csr_data, .errors, .pending
   );

   // Receiver: pop most cycles, stall now and then unless in a quiet stretch.
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         pop <= quiet || ($urandom_range(99) >= 6);
      end
   end

   // Watchdog: end the run if the block hangs.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   // Hold one request until accepted; call at a falling edge, return at one.
   task automatic send_request(req_type q);
      while (!quiet && $urandom_range(99) < 6) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push     <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (full) @(posedge clock);
      @(negedge clock);
      requests_sent++;
   endtask

   task automatic send_pixel(logic [7:0] value);
      req_type q;
      q.operation = OP_PIXEL;
      q.pixel     = value;
      q.se_row    = 5'($urandom);
      q.se_bits   = 19'($urandom);
      send_request(q);
   endtask

   task automatic send_mask_row(logic [4:0] row, logic [18:0] bits);
      req_type q;
      q.operation = OP_SE;
      q.pixel     = 8'($urandom);
      q.se_row    = row;
      q.se_bits   = bits;
      send_request(q);
   endtask

   // Drop push, drain every expected result, then let the pipeline empty.
   task automatic settle();
      push <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   // Raise the write for one cycle; the caller drops csr_write after the last.
   task automatic write_reg(logic [1:0] index, logic [12:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(negedge clock);
   endtask

   task automatic configure(logic m, logic [12:0] w, logic [12:0] h, logic [3:0] r);
      settle();
      write_reg(CSR_MODE, {12'd0, m});
      write_reg(CSR_WIDTH, w);
      write_reg(CSR_HEIGHT, h);
      write_reg(CSR_RADIUS, {9'd0, r});
      csr_write <= 1'b0;
   endtask

   // Load all element rows: 0 empty, 1 full, else random density.
   task automatic load_mask(int kind);
      logic [18:0] bits;
      for (int i = 0; i < MaxSe; i++) begin
         case (kind)
            0: bits = '0;
            1: bits = '1;
            default: bits = 19'($urandom) | ($urandom_range(1) ? 19'($urandom) : '0);
         endcase
         send_mask_row(5'(i), bits);
      end
   endtask

   // One whole frame; sprinkle mask-row loads (some out of range) in between.
   task automatic send_frame(int unsigned w, int unsigned h);
      int unsigned roll;
      for (int unsigned n = 0; n < w * h; n++) begin
         if ($urandom_range(99) < 3) send_mask_row(5'($urandom), 19'($urandom));
         roll = $urandom_range(99);
         if (roll < 10) send_pixel(8'd0);
         else if (roll < 20) send_pixel(8'd255);
         else send_pixel(8'($urandom));
      end
   endtask

   initial begin
      int unsigned rnd_start, r, w, h, frames;
      logic m;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty mask: erosion yields 255, dilation yields 0.
      configure(1'b0, 13'd3, 13'd3, 4'd1);
      send_frame(3, 3);
      configure(1'b1, 13'd3, 13'd3, 4'd1);
      send_frame(3, 3);
      // Full mask, out-of-range row loads that must be ignored.
      load_mask(1);
      send_mask_row(5'd19, '0);
      send_mask_row(5'd31, '0);
      send_frame(3, 3);
      // Zero size saturates to one pixel, radius zero.
      configure(1'b0, 13'd0, 13'd0, 4'd0);
      send_pixel(8'd77);
      // Image smaller than the window: no results at all.
      configure(1'b0, 13'd3, 13'd3, 4'd2);
      send_frame(3, 3);
      // Radius above the limit saturates to the largest window.
      configure(1'b1, 13'd19, 13'd19, 4'd15);
      load_mask(2);
      send_frame(19, 19);
      // A long row and a tall column.
      configure(1'b0, 13'd400, 13'd1, 4'd0);
      send_frame(400, 1);
      configure(1'b1, 13'd1, 13'd200, 4'd0);
      send_frame(1, 200);

      // Random frames with random settings, mostly small.
      rnd_start = requests_sent;
      while (requests_sent < 1750) begin
         quiet = (requests_sent - rnd_start >= 200) && (requests_sent - rnd_start < 450);
         m = 1'($urandom);
         r = ($urandom_range(9) == 0) ? $urandom_range(MaxRadius) : $urandom_range(2);
         w = 2 * r + 1 + $urandom_range(6);
         h = 2 * r + 1 + $urandom_range(4);
         if ($urandom_range(9) == 0) h = (r == 0) ? 1 : $urandom_range(2 * r, 1);
         configure(m, 13'(w), 13'(h), 4'(r));
         load_mask($urandom_range(9) == 0 ? $urandom_range(1) : 2);
         frames = $urandom_range(2, 1);
         repeat (frames) send_frame(w, h);
      end
      quiet = 1'b0;

      settle();
      if (errors == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
